// ----- hw/rtl/cluster_centroid_update_top_macros.svh -----
`ifndef CLUSTER_CENTROID_UPDATE_TOP_MACROS_SVH
`define CLUSTER_CENTROID_UPDATE_TOP_MACROS_SVH

// same-cycle implication
`define CCU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ccu_pkg.sv -----
package ccu_pkg;

    localparam int MAX_CLUSTERS = 64;
    localparam int DIMENSIONS   = 16;
    localparam int CELLS        = MAX_CLUSTERS * DIMENSIONS;
    localparam int CL_ADDR_W    = $clog2(MAX_CLUSTERS);
    localparam int CELL_W       = $clog2(CELLS);

    localparam int KIND_W       = 2;
    localparam int CLUSTER_W    = 7;
    localparam int COORD_IDX_W  = 4;
    localparam int VALUE_W      = 16;
    localparam int WEIGHT_W     = 16;
    localparam int STATUS_W     = 2;
    localparam int SUM_W        = 56;
    localparam int TOTAL_W      = 40;
    localparam int PROD_W       = VALUE_W + WEIGHT_W + 2;
    localparam int REM_W        = SUM_W + 1;
    localparam int QUOT_W       = VALUE_W;
    localparam int DSH_W        = TOTAL_W + QUOT_W;
    localparam int QCNT_W       = $clog2(QUOT_W + 1);

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int CL_COUNT_W   = 7;
    localparam int FROZEN_W     = 6;

    localparam logic [CL_COUNT_W-1:0] CL_COUNT_RST = CL_COUNT_W'(64);
    localparam logic [WEIGHT_W:0]     ONE_Q8_8     = (WEIGHT_W + 1)'(256);

    localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W - 1){1'b0}}};
    localparam logic [TOTAL_W-1:0]        TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic signed [VALUE_W-1:0] MEAN_MAX  = {1'b0, {(VALUE_W - 1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] MEAN_MIN  = {1'b1, {(VALUE_W - 1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_ACC,
        KIND_READ,
        KIND_CLEAR,
        KIND_NOP
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_INVALID,
        ST_FROZEN,
        ST_EMPTY
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLUSTER_COUNT,
        CFG_FROZEN_COUNT,
        CFG_USE_WEIGHTS
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PREP,
        S_DIV,
        S_CLR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                     clear;
        logic [CELL_W-1:0]        rd_cell;
        logic [CL_ADDR_W-1:0]     rd_cl;
        logic                     wr_en;
        logic                     wr_tot_en;
        logic [CELL_W-1:0]        wr_cell;
        logic [CL_ADDR_W-1:0]     wr_cl;
        logic signed [SUM_W-1:0]  wr_sum;
        logic [TOTAL_W-1:0]       wr_tot;
    } t_store_req;

    typedef struct packed {
        logic                     busy;
        logic signed [SUM_W-1:0]  rd_sum;
        logic [TOTAL_W-1:0]       rd_tot;
    } t_store_rsp;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     mag;
        logic [TOTAL_W-1:0]   tot;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [QUOT_W-1:0]    quot;
    } t_div_rsp;

endpackage

// ----- hw/rtl/ccu_if.sv -----
interface ccu_in_if import ccu_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic [CLUSTER_W-1:0]        cluster;
    logic [COORD_IDX_W-1:0]      coord_index;
    logic signed [VALUE_W-1:0]   coord_value;
    logic [WEIGHT_W-1:0]         point_weight;

    modport source (output valid, kind, cluster, coord_index, coord_value, point_weight,
                    input ready);
    modport sink   (input valid, kind, cluster, coord_index, coord_value, point_weight,
                    output ready);
endinterface

interface ccu_out_if import ccu_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic signed [VALUE_W-1:0]   mean_value;
    logic [TOTAL_W-1:0]          weight_total;

    modport source (output valid, status, mean_value, weight_total, input ready);
    modport sink   (input valid, status, mean_value, weight_total, output ready);
endinterface

interface ccu_cfg_if import ccu_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [CFG_IDX_W-1:0]        index;
    logic [CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/cluster_centroid_update_top.sv -----
// channel   dir  handshake      payload
// i_cfg     in   valid/ready    index, data
// i_in      in   valid/ready    kind, cluster, coord_index, coord_value, point_weight
// o_out     out  valid/ready    status, mean_value, weight_total
//
// one item at a time: accumulate goes S_MOD then S_OUT, a rejected or unused kind goes
// straight to S_OUT, a read adds S_PREP and the 16-step shift-subtract divider (empty read skips both)
// clear waits in S_CLR for the pass over all 1024 cells, one cell of the sum memory written per cycle
// after reset the same clearing pass runs before i_in.ready rises
// a registered result waits in the output register while the next item enters
`include "cluster_centroid_update_top_macros.svh"

module cluster_centroid_update_top import ccu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ccu_cfg_if.sink   i_cfg,
    ccu_in_if.sink    i_in,
    ccu_out_if.source o_out
);

    t_state r_state, n_state;

    logic [CL_COUNT_W-1:0] r_cluster_count;
    logic [FROZEN_W-1:0]   r_frozen_count;
    logic                  r_use_weights;

    t_kind                    r_kind;
    logic [CELL_W-1:0]        r_cell;
    logic [CL_ADDR_W-1:0]     r_cl;
    logic                     r_ci_zero;
    logic [WEIGHT_W:0]        r_wt;
    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]         r_mag;
    logic                     r_neg;
    logic [TOTAL_W-1:0]       r_tot;

    t_status                   r_res_status;
    logic signed [VALUE_W-1:0] r_res_mean;
    logic [TOTAL_W-1:0]        r_res_total;

    logic                      r_out_valid;
    t_status                   r_out_status;
    logic signed [VALUE_W-1:0] r_out_mean;
    logic [TOTAL_W-1:0]        r_out_total;

    t_store_req w_store_req;
    t_store_rsp w_store_rsp;
    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;

    logic                      w_in_ready;
    logic                      w_in_xfer;
    logic                      w_out_load;
    t_kind                     w_kind;
    logic                      w_invalid;
    logic                      w_frozen;
    logic [WEIGHT_W:0]         w_wt;
    logic signed [REM_W-1:0]   w_sum_wide;
    logic signed [SUM_W-1:0]   w_new_sum;
    logic [TOTAL_W:0]          w_tot_wide;
    logic [TOTAL_W-1:0]        w_new_tot;
    logic [SUM_W-1:0]          w_mag;
    logic signed [VALUE_W-1:0] w_mean;

    ccu_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_store_req),
        .o_rsp   (w_store_rsp)
    );

    ccu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CL_COUNT_RST;
            r_frozen_count  <= '0;
            r_use_weights   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CLUSTER_COUNT: r_cluster_count <= CL_COUNT_W'(i_cfg.data);
                CFG_FROZEN_COUNT:  r_frozen_count  <= FROZEN_W'(i_cfg.data);
                CFG_USE_WEIGHTS:   r_use_weights   <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // item classification
    assign w_kind    = t_kind'(i_in.kind);
    assign w_invalid = (i_in.cluster >= r_cluster_count)
                    || (32'(i_in.cluster) >= MAX_CLUSTERS)
                    || (32'(i_in.coord_index) >= DIMENSIONS);
    assign w_frozen  = i_in.cluster < CLUSTER_W'(r_frozen_count);
    assign w_wt      = r_use_weights ? {1'b0, i_in.point_weight} : ONE_Q8_8;
    assign w_in_xfer = i_in.valid && w_in_ready;

    // read-modify-write arithmetic
    assign w_sum_wide = REM_W'(w_store_rsp.rd_sum) + REM_W'(r_prod);
    assign w_tot_wide = {1'b0, w_store_rsp.rd_tot} + (TOTAL_W + 1)'(r_wt);
    assign w_mag      = w_store_rsp.rd_sum[SUM_W-1] ? SUM_W'(-w_store_rsp.rd_sum)
                                                    : SUM_W'(w_store_rsp.rd_sum);

    always_comb begin
        if (w_sum_wide[REM_W-1] != w_sum_wide[REM_W-2]) begin
            w_new_sum = w_sum_wide[REM_W-1] ? SUM_MIN : SUM_MAX;
        end else begin
            w_new_sum = SUM_W'(w_sum_wide);
        end
        w_new_tot = w_tot_wide[TOTAL_W] ? TOTAL_MAX : w_tot_wide[TOTAL_W-1:0];
    end

    always_comb begin
        if (r_neg) begin
            w_mean = w_div_rsp.quot[QUOT_W-1] ? MEAN_MIN : VALUE_W'(-w_div_rsp.quot);
        end else begin
            w_mean = w_div_rsp.quot[QUOT_W-1] ? MEAN_MAX : VALUE_W'(w_div_rsp.quot);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (w_kind == KIND_CLEAR) begin
                        n_state = S_CLR;
                    end else if (w_kind == KIND_NOP || w_invalid || w_frozen) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (r_kind == KIND_READ && w_store_rsp.rd_tot != '0) begin
                    n_state = S_PREP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_CLR: begin
                if (!w_store_rsp.busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready = (r_state == S_IDLE) && !w_store_rsp.busy;
        w_out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

        w_store_req.clear     = w_in_xfer && (w_kind == KIND_CLEAR);
        w_store_req.rd_cell   = CELL_W'(32'(i_in.cluster) * DIMENSIONS
                                        + 32'(i_in.coord_index));
        w_store_req.rd_cl     = CL_ADDR_W'(i_in.cluster);
        w_store_req.wr_en     = (r_state == S_MOD) && (r_kind == KIND_ACC);
        w_store_req.wr_tot_en = (r_state == S_MOD) && (r_kind == KIND_ACC) && r_ci_zero;
        w_store_req.wr_cell   = r_cell;
        w_store_req.wr_cl     = r_cl;
        w_store_req.wr_sum    = w_new_sum;
        w_store_req.wr_tot    = w_new_tot;

        w_div_req.start = (r_state == S_PREP);
        w_div_req.mag   = r_mag;
        w_div_req.tot   = r_tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item and result registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_kind      <= w_kind;
            r_cell      <= w_store_req.rd_cell;
            r_cl        <= w_store_req.rd_cl;
            r_ci_zero   <= (i_in.coord_index == '0);
            r_wt        <= w_wt;
            r_prod      <= i_in.coord_value * $signed({1'b0, w_wt});
            r_res_mean  <= '0;
            r_res_total <= '0;
            if (w_kind == KIND_CLEAR || w_kind == KIND_NOP) begin
                r_res_status <= ST_OK;
            end else if (w_invalid) begin
                r_res_status <= ST_INVALID;
            end else if (w_frozen) begin
                r_res_status <= ST_FROZEN;
            end else begin
                r_res_status <= ST_OK;
            end
        end else if (r_state == S_MOD) begin
            if (r_kind == KIND_ACC) begin
                r_res_total <= r_ci_zero ? w_new_tot : w_store_rsp.rd_tot;
            end else if (w_store_rsp.rd_tot == '0) begin
                r_res_status <= ST_EMPTY;
            end else begin
                r_mag       <= w_mag;
                r_neg       <= w_store_rsp.rd_sum[SUM_W-1];
                r_tot       <= w_store_rsp.rd_tot;
                r_res_total <= w_store_rsp.rd_tot;
            end
        end else if (r_state == S_DIV && w_div_rsp.done) begin
            r_res_mean <= w_mean;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_mean   <= r_res_mean;
            r_out_total  <= r_res_total;
        end
    end

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.mean_value   = r_out_mean;
    assign o_out.weight_total = r_out_total;

    `CCU_ASSERT_SAME(a_no_write_while_clearing, w_store_req.wr_en, !w_store_rsp.busy, "store write during clearing pass")
    `CCU_ASSERT_SAME(a_mod_after_transfer, r_state == S_MOD, $past(w_in_xfer), "modify step without an input transfer")
    `CCU_ASSERT_SAME(a_div_done_while_waiting, w_div_rsp.done, r_state == S_DIV, "divider finished outside its wait state")
    `CCU_ASSERT_NEXT(a_load_after_out, w_out_load, r_out_valid && r_state == S_IDLE, "result load did not fill output register")
    `CCU_ASSERT_SAME(a_total_only_when_ok, o_out.valid && o_out.weight_total != '0, o_out.status == ST_OK, "nonzero total with a failing status")

endmodule

// ----- hw/rtl/ccu_store.sv -----
module ccu_store import ccu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output t_store_rsp o_rsp
);

    logic signed [SUM_W-1:0] r_sum_mem [CELLS];
    logic [TOTAL_W-1:0]      r_tot_mem [MAX_CLUSTERS];

    logic                    r_clr_active;
    logic [CELL_W-1:0]       r_clr_cnt;
    logic signed [SUM_W-1:0] r_rd_sum;
    logic [TOTAL_W-1:0]      r_rd_tot;

    // clearing pass over every cell, totals ride along on the low addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
        end else if (i_req.clear) begin
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
        end else if (r_clr_active) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CELL_W'(CELLS - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_sum_mem[r_clr_cnt] <= '0;
            if (32'(r_clr_cnt) < MAX_CLUSTERS) begin
                r_tot_mem[CL_ADDR_W'(r_clr_cnt)] <= '0;
            end
        end else if (i_req.wr_en) begin
            r_sum_mem[i_req.wr_cell] <= i_req.wr_sum;
            if (i_req.wr_tot_en) begin
                r_tot_mem[i_req.wr_cl] <= i_req.wr_tot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_sum <= r_sum_mem[i_req.rd_cell];
        r_rd_tot <= r_tot_mem[i_req.rd_cl];
    end

    assign o_rsp.busy   = r_clr_active;
    assign o_rsp.rd_sum = r_rd_sum;
    assign o_rsp.rd_tot = r_rd_tot;

endmodule

// ----- hw/rtl/ccu_div.sv -----
module ccu_div import ccu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                r_busy;
    logic                r_done;
    logic [QCNT_W-1:0]   r_cnt;
    logic [REM_W-1:0]    r_rem;
    logic [DSH_W-1:0]    r_dsh;
    logic [QUOT_W-1:0]   r_quot;
    logic                w_ge;

    assign w_ge = r_rem >= REM_W'(r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= QCNT_W'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend 2*mag + tot over divisor 2*tot, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {i_req.mag, 1'b0} + REM_W'(i_req.tot);
            r_dsh  <= {i_req.tot, {QUOT_W{1'b0}}};
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - REM_W'(r_dsh);
            end
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
